[src/vec3_normalize_defines.svh]
// Assertion helpers shared by the checker
`ifndef VEC3_NORMALIZE_DEFINES_SVH
`define VEC3_NORMALIZE_DEFINES_SVH

// same-cycle implication
`define VN_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define VN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/vn_pkg.sv]
package vn_pkg;
    localparam int FIELD_W   = 32;
    localparam int UNIT_W    = 16;
    localparam int MAG_W     = 32;
    localparam int UNIT_FRAC = 14;
    localparam int QUOT_W    = UNIT_FRAC + 1;
endpackage

[src/vn_in_if.sv]
interface vn_in_if;
    import vn_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] coord_x;
    logic signed [FIELD_W-1:0] coord_y;
    logic signed [FIELD_W-1:0] coord_z;

    modport source (output valid, coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

[src/vn_out_if.sv]
interface vn_out_if;
    import vn_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [UNIT_W-1:0] unit_x;
    logic signed [UNIT_W-1:0] unit_y;
    logic signed [UNIT_W-1:0] unit_z;
    logic        [MAG_W-1:0]  magnitude;
    logic                     zero_length;

    modport source (output valid, unit_x, unit_y, unit_z, magnitude, zero_length, input ready);
    modport sink   (input valid, unit_x, unit_y, unit_z, magnitude, zero_length, output ready);
endinterface

[src/vec3_normalize.sv]
// Throughput: one transaction per cycle when the output is not stalled.
// The sqrt stages (one root bit each) and the divide stages (one quotient
// bit each, three lanes) are fully pipelined.
// Back-pressure on the output freezes the whole pipeline in place.
// Reset (rst_n, async, active low) clears only the stage valid bits.
module vec3_normalize #(
    parameter int COORD_WIDTH = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    vn_in_if.sink    vec_in,
    vn_out_if.source vec_out
);
    import vn_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int SW  = 2 * W;
    localparam int RW  = W + 2;
    localparam int NW  = W + UNIT_FRAC;
    localparam int NST = W + QUOT_W + 4;

    logic           en;
    logic [NST-1:0] vld_reg;

    assign en           = !vld_reg[NST-1] || vec_out.ready;
    assign vec_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], vec_in.valid};
    end

    // front: abs value, squares, sum
    logic [W-1:0]  raw [3];
    logic [W-1:0]  abs0_reg [3];
    logic          neg0_reg [3];
    logic [SW-1:0] sq1_reg  [3];
    logic [W-1:0]  abs1_reg [3];
    logic          neg1_reg [3];
    logic [SW-1:0] sum2_reg;
    logic [W-1:0]  abs2_reg [3];
    logic          neg2_reg [3];

    assign raw[0] = vec_in.coord_x[W-1:0];
    assign raw[1] = vec_in.coord_y[W-1:0];
    assign raw[2] = vec_in.coord_z[W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                neg0_reg[c] <= raw[c][W-1];
                abs0_reg[c] <= raw[c][W-1] ? (~raw[c] + 1'b1) : raw[c];
                sq1_reg[c]  <= SW'(abs0_reg[c]) * SW'(abs0_reg[c]);
                abs1_reg[c] <= abs0_reg[c];
                neg1_reg[c] <= neg0_reg[c];
                abs2_reg[c] <= abs1_reg[c];
                neg2_reg[c] <= neg1_reg[c];
            end
            sum2_reg <= sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
        end
    end

    // square root, one root bit per stage
    logic [SW-1:0] rad_reg  [W];
    logic [RW-1:0] rem_reg  [W];
    logic [W-1:0]  root_reg [W];
    logic [W-1:0]  sabs_reg [W][3];
    logic          sneg_reg [W][3];

    for (genvar k = 0; k < W; k++)
    begin : g_sqrt
        logic [SW-1:0] rad_in;
        logic [RW-1:0] rem_in;
        logic [W-1:0]  root_in;
        logic [W-1:0]  abs_in [3];
        logic          neg_in [3];
        logic [RW+1:0] rem_sh;
        logic [RW+1:0] trial;
        logic [RW+1:0] diff;
        logic          take;

        if (k == 0)
        begin : g_first
            assign rad_in  = sum2_reg;
            assign rem_in  = '0;
            assign root_in = '0;
            for (genvar c = 0; c < 3; c++)
            begin : g_l
                assign abs_in[c] = abs2_reg[c];
                assign neg_in[c] = neg2_reg[c];
            end
        end
        else
        begin : g_next
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            for (genvar c = 0; c < 3; c++)
            begin : g_l
                assign abs_in[c] = sabs_reg[k-1][c];
                assign neg_in[c] = sneg_reg[k-1][c];
            end
        end

        assign rem_sh = {rem_in, rad_in[SW-1 -: 2]};
        assign trial  = {2'b00, root_in, 2'b01};
        assign take   = rem_sh >= trial;
        assign diff   = rem_sh - trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= rad_in << 2;
                rem_reg[k]  <= take ? diff[RW-1:0] : rem_sh[RW-1:0];
                root_reg[k] <= {root_in[W-2:0], take};
                for (int c = 0; c < 3; c++)
                begin
                    sabs_reg[k][c] <= abs_in[c];
                    sneg_reg[k][c] <= neg_in[c];
                end
            end
        end
    end

    // restoring divide, one quotient bit per stage, three lanes
    logic [W-1:0]      dv_reg   [QUOT_W];
    logic [NW-1:0]     dr_reg   [QUOT_W][3];
    logic [QUOT_W-1:0] dq_reg   [QUOT_W][3];
    logic              dneg_reg [QUOT_W][3];

    for (genvar j = 0; j < QUOT_W; j++)
    begin : g_div
        localparam int BIT = QUOT_W - 1 - j;
        logic [W-1:0]      d_in;
        logic [NW-1:0]     r_in   [3];
        logic [QUOT_W-1:0] q_in   [3];
        logic              neg_in [3];
        logic [NW:0]       dsh;
        logic [NW:0]       r_ext  [3];
        logic [NW:0]       r_sub  [3];
        logic [NW-1:0]     r_next [3];
        logic [QUOT_W-1:0] q_next [3];

        if (j == 0)
        begin : g_first
            assign d_in = root_reg[W-1];
            for (genvar c = 0; c < 3; c++)
            begin : g_l
                assign r_in[c]   = {sabs_reg[W-1][c], {UNIT_FRAC{1'b0}}};
                assign q_in[c]   = '0;
                assign neg_in[c] = sneg_reg[W-1][c];
            end
        end
        else
        begin : g_next
            assign d_in = dv_reg[j-1];
            for (genvar c = 0; c < 3; c++)
            begin : g_l
                assign r_in[c]   = dr_reg[j-1][c];
                assign q_in[c]   = dq_reg[j-1][c];
                assign neg_in[c] = dneg_reg[j-1][c];
            end
        end

        assign dsh = (NW+1)'(d_in) << BIT;

        always_comb
        begin
            for (int c = 0; c < 3; c++)
            begin
                r_ext[c]  = {1'b0, r_in[c]};
                r_sub[c]  = r_ext[c] - dsh;
                q_next[c] = q_in[c];
                if (r_ext[c] >= dsh)
                begin
                    r_next[c]      = r_sub[c][NW-1:0];
                    q_next[c][BIT] = 1'b1;
                end
                else
                begin
                    r_next[c] = r_in[c];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[j] <= d_in;
                for (int c = 0; c < 3; c++)
                begin
                    dr_reg[j][c]   <= r_next[c];
                    dq_reg[j][c]   <= q_next[c];
                    dneg_reg[j][c] <= neg_in[c];
                end
            end
        end
    end

    // output stage: sign, zero-vector override
    logic [UNIT_W-1:0] unit_reg [3];
    logic [MAG_W-1:0]  mag_reg;
    logic              zero_reg;
    logic              len_zero;
    logic [UNIT_W-1:0] qext [3];

    assign len_zero = dv_reg[QUOT_W-1] == '0;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            qext[c] = {1'b0, dq_reg[QUOT_W-1][c]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (len_zero)
                    unit_reg[c] <= '0;
                else if (dneg_reg[QUOT_W-1][c])
                    unit_reg[c] <= ~qext[c] + 1'b1;
                else
                    unit_reg[c] <= qext[c];
            end
            mag_reg  <= MAG_W'(dv_reg[QUOT_W-1]);
            zero_reg <= len_zero;
        end
    end

    assign vec_out.valid       = vld_reg[NST-1];
    assign vec_out.unit_x      = unit_reg[0];
    assign vec_out.unit_y      = unit_reg[1];
    assign vec_out.unit_z      = unit_reg[2];
    assign vec_out.magnitude   = mag_reg;
    assign vec_out.zero_length = zero_reg;
endmodule

[src/vn_checker.sv]
`include "vec3_normalize_defines.svh"

module vn_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] ux,
    input logic signed [15:0] uy,
    input logic signed [15:0] uz,
    input logic        [31:0] mag,
    input logic               zl
);
    logic units_in_range;

    assign units_in_range = ux <= 16'sd16384 && ux >= -16'sd16384
                         && uy <= 16'sd16384 && uy >= -16'sd16384
                         && uz <= 16'sd16384 && uz >= -16'sd16384;

    // a stalled result holds
    `VN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(mag) && $stable(ux))
    // a full, stalled pipe takes no new transaction
    `VN_ASSERT_IMPLY(a_stall, out_valid && !out_ready, !in_ready)
    `VN_ASSERT_IMPLY(a_zero, out_valid && zl, ux == 0 && uy == 0 && uz == 0 && mag == 0)
    `VN_ASSERT_IMPLY(a_nonzero, out_valid && !zl, mag != 0)
    `VN_ASSERT_IMPLY(a_range, out_valid, units_in_range)
endmodule

bind vec3_normalize vn_checker u_vn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (vec_in.ready),
    .out_valid (vec_out.valid),
    .out_ready (vec_out.ready),
    .ux        (vec_out.unit_x),
    .uy        (vec_out.unit_y),
    .uz        (vec_out.unit_z),
    .mag       (vec_out.magnitude),
    .zl        (vec_out.zero_length)
);

[test/vn_channels.sv]
// Channel interfaces vn_in_if and vn_out_if come from the RTL sources.

[test/vec3_normalize_checker.sv]
module vec3_normalize_checker #(
    parameter int COORD_WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    vn_in_if     vec_in,
    vn_out_if    vec_out,
    output int   fail_count,
    output int   pending_count,
    output int   result_count,
    output int   zero_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import vn_pkg::*;

    typedef struct packed {
        logic [UNIT_W-1:0] ux;
        logic [UNIT_W-1:0] uy;
        logic [UNIT_W-1:0] uz;
        logic [MAG_W-1:0]  mag;
        logic              zero;
    } unit_vec_t;

    unit_vec_t unit_vec_q[$];

    initial begin
        fail_count   = 0;
        result_count = 0;
        zero_count   = 0;
    end

    assign pending_count = unit_vec_q.size();

    function automatic logic [63:0] abs_coord(input logic [FIELD_W-1:0] raw,
                                              output logic neg);
        logic [63:0] v;
        v   = 64'(raw) & ((64'd1 << COORD_WIDTH) - 64'd1);
        neg = v[COORD_WIDTH-1];
        if (neg)
            v = (~v + 64'd1) & ((64'd1 << COORD_WIDTH) - 64'd1);
        return v;
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] rem, root, b;
        rem  = v;
        root = 0;
        b    = 64'd1 << 62;
        while (b > rem)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= root + b)
            begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic logic [UNIT_W-1:0] scale_comp(input logic [63:0] a, input logic neg,
                                                     input logic [63:0] len);
        logic [63:0] q;
        if (len == 0)
            return '0;
        q = (a << UNIT_FRAC) / len;
        if (neg)
            q = ~q + 64'd1;
        return q[UNIT_W-1:0];
    endfunction

    function automatic unit_vec_t normalize(input logic [FIELD_W-1:0] x,
                                            input logic [FIELD_W-1:0] y,
                                            input logic [FIELD_W-1:0] z);
        unit_vec_t r;
        logic nx, ny, nz;
        logic [63:0] ax, ay, az, len;
        ax    = abs_coord(x, nx);
        ay    = abs_coord(y, ny);
        az    = abs_coord(z, nz);
        len   = root_floor(ax * ax + ay * ay + az * az);
        r.ux  = scale_comp(ax, nx, len);
        r.uy  = scale_comp(ay, ny, len);
        r.uz  = scale_comp(az, nz, len);
        r.mag = len[MAG_W-1:0];
        r.zero = (len == 0);
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("[%0t] %s: got %0h, want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        unit_vec_t w;
        if (rst_n)
        begin
            if (vec_in.valid && vec_in.ready)
                unit_vec_q.push_back(normalize(vec_in.coord_x, vec_in.coord_y, vec_in.coord_z));
            if (vec_out.valid && vec_out.ready)
            begin
                result_count++;
                if (vec_out.zero_length)
                    zero_count++;
                if (unit_vec_q.size() == 0)
                    report("unexpected transaction", vec_out.magnitude, 0);
                else
                begin
                    w = unit_vec_q.pop_front();
                    if (vec_out.unit_x !== w.ux)
                        report("unit_x", vec_out.unit_x, w.ux);
                    if (vec_out.unit_y !== w.uy)
                        report("unit_y", vec_out.unit_y, w.uy);
                    if (vec_out.unit_z !== w.uz)
                        report("unit_z", vec_out.unit_z, w.uz);
                    if (vec_out.magnitude !== w.mag)
                        report("magnitude", vec_out.magnitude, w.mag);
                    if (vec_out.zero_length !== w.zero)
                        report("zero_length", vec_out.zero_length, w.zero);
                end
            end
        end
    end
endmodule

[test/vec3_normalize_test.sv]
module vec3_normalize_test;
    timeunit 1ns;
    timeprecision 1ps;
    import vn_pkg::*;

    localparam int N_RANDOM = 1700;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 80;

    logic clk;
    logic rst_n;
    int   fail_count, pending_count, result_count, zero_count;
    int   idle_cycles;
    int   sent;

    vn_in_if  vec_in();
    vn_out_if vec_out();

    vec3_normalize u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .vec_in  (vec_in),
        .vec_out (vec_out)
    );

    vec3_normalize_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .vec_in        (vec_in),
        .vec_out       (vec_out),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_count  (result_count),
        .zero_count    (zero_count)
    );

    initial
        clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver stall pattern: modes change every so often, some stall-free
    initial
    begin
        int mode;
        int left;
        vec_out.ready = 1'b0;
        mode = 0;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(10, 200);
            end
            left--;
            case (mode)
                0: vec_out.ready <= 1'b1;
                1: vec_out.ready <= ($urandom_range(0, 3) != 0);
                2: vec_out.ready <= ($urandom_range(0, 1) != 0);
                default: vec_out.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (vec_in.valid && vec_in.ready) || (vec_out.valid && vec_out.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [FIELD_W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return FIELD_W'($signed($urandom_range(0, 131072)) - 65536);
            2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
            3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            4: return '0;
            default: return FIELD_W'($signed($urandom) >>> $urandom_range(0, 31));
        endcase
    endfunction

    // holds valid until the transaction is accepted; valid stays high across bursts
    task automatic send(input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y,
                        input logic [FIELD_W-1:0] z, input bit keep);
        vec_in.valid   <= 1'b1;
        vec_in.coord_x <= x;
        vec_in.coord_y <= y;
        vec_in.coord_z <= z;
        @(posedge clk);
        while (!vec_in.ready)
            @(posedge clk);
        sent++;
        @(negedge clk);
        if (!keep)
            vec_in.valid <= 1'b0;
    endtask

    initial
    begin
        int burst;
        int gap;
        rst_n          = 1'b0;
        vec_in.valid   = 1'b0;
        vec_in.coord_x = '0;
        vec_in.coord_y = '0;
        vec_in.coord_z = '0;
        sent           = 0;
        idle_cycles    = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero vector, axis extremes, mixed signs, tiny lengths
        send(0, 0, 0, 1'b0);
        send(32'h7fff_ffff, 0, 0, 1'b0);
        send(32'h8000_0000, 0, 0, 1'b0);
        send(0, 32'h8000_0000, 0, 1'b0);
        send(0, 0, 32'h7fff_ffff, 1'b0);
        send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        send(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
        send(1, 0, 0, 1'b0);
        send(32'hffff_ffff, 0, 0, 1'b0);
        send(1, 1, 1, 1'b0);
        send(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
        send(32'h0001_0000, 32'h0001_0000, 0, 1'b0);
        send(32'h0003_0000, 32'hfffc_0000, 0, 1'b0);
        send(32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678, 1'b0);
        send(0, 0, 1, 1'b0);
        send(32'hffff_0000, 32'h0000_ffff, 32'h8000_0001, 1'b0);

        // hold off until the pipeline has drained
        while (pending_count != 0)
            @(negedge clk);

        while (sent < 17 + N_RANDOM)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && sent < 17 + N_RANDOM)
            begin
                burst--;
                send(rand_coord(), rand_coord(), rand_coord(), burst > 0);
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            repeat (gap) @(negedge clk);
            if ($urandom_range(0, 60) == 0)
                while (pending_count != 0)
                    @(negedge clk);
        end
        vec_in.valid <= 1'b0;

        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d vectors (directed extremes plus random bursts), checked %0d results.",
                 sent, result_count);
        $display("Zero-length results seen: %0d, mismatches: %0d.", zero_count, fail_count);
        if (fail_count == 0 && pending_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
